>>> design/mpc_pkg.sv
// ----------------------------------------------------------------------------
// mpc_pkg: shared types and constants for the masked correlation block
// Payload structs, controller/datapath command and status, step codes.
// ----------------------------------------------------------------------------
package mpc_pkg;

    localparam int MAX_VOXELS_DEF  = 2097152;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_SIGN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMEAN    = 2'd2;

    localparam int THR_RESET = 3277;

    // accumulator widths
    localparam int CNT_FW = 22;
    localparam int SUM_W  = 38;
    localparam int SQ_W   = 52;

    // finalize widths
    localparam int V_W  = 74;   // variances, numerator
    localparam int MX_W = 148;  // multiplicand
    localparam int MY_W = 74;   // multiplier
    localparam int MP_W = 180;  // product

    localparam logic [15:0] HI_INIT = 16'd32768;

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_P   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_Q   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_NA  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SA  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_NB  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SB  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DEN = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LHS = 4'd7;
    localparam logic [STEP_W-1:0] STEP_K2  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_KD  = 4'd9;

    typedef struct packed {
        logic signed [15:0] sample_a;
        logic signed [15:0] sample_b;
        logic               in_mask;
        logic               last_voxel;
    } t_in;

    typedef struct packed {
        logic signed [15:0] score;
        logic               above_threshold;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        logic              mul_start;
        logic              capture;
        logic              raw_load;
        logic              srch_init;
        logic              out_load;
        logic [STEP_W-1:0] step;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic lo_lt_hi;
        logic demean;
    } t_sts;

endpackage

>>> design/mpc_mul.sv
// ----------------------------------------------------------------------------
// mpc_mul: shift-add multiplier
// One multiplier bit per cycle; finishes as soon as the remaining bits are 0.
// ----------------------------------------------------------------------------
module mpc_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [mpc_pkg::MX_W-1:0] i_x,
    input  logic [mpc_pkg::MY_W-1:0] i_y,
    output logic                     o_done,
    output logic [mpc_pkg::MP_W-1:0] o_prod
);
    import mpc_pkg::*;

    logic [MP_W-1:0] r_acc;
    logic [MP_W-1:0] r_xs;
    logic [MY_W-1:0] r_y;
    logic            r_busy;

    assign o_done = r_busy && (r_y == '0);
    assign o_prod = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_xs  <= MP_W'(i_x);
            r_y   <= i_y;
        end else if (r_busy && (r_y != '0)) begin
            if (r_y[0]) begin
                r_acc <= r_acc + r_xs;
            end
            r_xs <= {r_xs[MP_W-2:0], 1'b0};
            r_y  <= {1'b0, r_y[MY_W-1:1]};
        end
    end

endmodule

>>> design/mpc_dp.sv
// ----------------------------------------------------------------------------
// mpc_dp: datapath
// Config registers, voxel accumulators, finalize registers, search bounds
// and the result register.
// ----------------------------------------------------------------------------
module mpc_dp #(
    parameter int MAX_VOXELS  = mpc_pkg::MAX_VOXELS_DEF,
    parameter int SAMPLE_BITS = mpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_fire,
    input  mpc_pkg::t_in                  i_in,
    input  logic                          i_cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mpc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    input  mpc_pkg::t_cmd                 i_cmd,
    output mpc_pkg::t_sts                 o_sts,
    output logic [mpc_pkg::MX_W-1:0]      o_mul_x,
    output logic [mpc_pkg::MY_W-1:0]      o_mul_y,
    input  logic [mpc_pkg::MP_W-1:0]      i_prod,
    output mpc_pkg::t_out                 o_out
);
    import mpc_pkg::*;

    localparam int CNT_W = $clog2(MAX_VOXELS + 1);
    // cross sum reaches +2^51 when every sample pair is (-32768, -32768)
    localparam int SAB_W = SQ_W + 1;

    logic [14:0] r_thr;
    logic        r_keep;
    logic        r_demean;

    logic [CNT_W-1:0]        r_cnt;
    logic signed [SUM_W-1:0] r_sa, r_sb;
    logic [SQ_W-1:0]         r_saa, r_sbb;
    logic signed [SAB_W-1:0] r_sab;

    logic [V_W-1:0]  r_p, r_t, r_num, r_va, r_vb;
    logic            r_neg;
    logic [MX_W-1:0] r_den;
    logic [MP_W-1:0] r_lhs;
    logic [31:0]     r_k2;
    logic [15:0]     r_lo, r_hi;
    t_out            r_out;

    logic signed [15:0] a_s, b_s;
    logic signed [31:0] aa, bb, ab;
    logic               add_en;
    logic [SUM_W-1:0]   mag_sa, mag_sb;
    logic [SQ_W-1:0]    mag_sab;
    logic [CNT_FW-1:0]  cnt_x;
    logic [16:0]        mid_sum;
    logic [15:0]        mid, k;
    logic [V_W-1:0]     pl;
    logic               qneg;
    logic               degen;
    logic [15:0]        sc_pos;
    logic signed [15:0] score;

    assign a_s    = $signed(i_in.sample_a[SAMPLE_BITS-1:0]);
    assign b_s    = $signed(i_in.sample_b[SAMPLE_BITS-1:0]);
    assign aa     = a_s * a_s;
    assign bb     = b_s * b_s;
    assign ab     = a_s * b_s;
    assign add_en = i_in_fire && i_in.in_mask && (r_cnt < CNT_W'(MAX_VOXELS));

    assign mag_sa  = r_sa[SUM_W-1] ? SUM_W'(-r_sa) : SUM_W'(r_sa);
    assign mag_sb  = r_sb[SUM_W-1] ? SUM_W'(-r_sb) : SUM_W'(r_sb);
    assign mag_sab = r_sab[SAB_W-1] ? SQ_W'(-r_sab) : SQ_W'(r_sab);
    assign cnt_x   = CNT_FW'(r_cnt);

    assign mid_sum = 17'(r_lo) + 17'(r_hi) + 17'd1;
    assign mid     = mid_sum[16:1];
    assign k       = 16'({mid, 1'b0} - 17'd1);

    assign pl   = i_prod[V_W-1:0];
    assign qneg = !(r_sa[SUM_W-1] ^ r_sb[SUM_W-1]);   // sign of -Sa*Sb

    assign degen = (r_va == '0) || (r_vb == '0);
    assign o_sts = '{degen: degen, lo_lt_hi: (r_lo < r_hi), demean: r_demean};

    always_comb begin
        o_mul_x = '0;
        o_mul_y = '0;
        case (i_cmd.step)
            STEP_P:   begin o_mul_x = MX_W'(mag_sab); o_mul_y = MY_W'(cnt_x);  end
            STEP_Q:   begin o_mul_x = MX_W'(mag_sa);  o_mul_y = MY_W'(mag_sb); end
            STEP_NA:  begin o_mul_x = MX_W'(r_saa);   o_mul_y = MY_W'(cnt_x);  end
            STEP_SA:  begin o_mul_x = MX_W'(mag_sa);  o_mul_y = MY_W'(mag_sa); end
            STEP_NB:  begin o_mul_x = MX_W'(r_sbb);   o_mul_y = MY_W'(cnt_x);  end
            STEP_SB:  begin o_mul_x = MX_W'(mag_sb);  o_mul_y = MY_W'(mag_sb); end
            STEP_DEN: begin o_mul_x = MX_W'(r_va);    o_mul_y = r_vb;          end
            STEP_LHS: begin o_mul_x = MX_W'(r_num);   o_mul_y = r_num;         end
            STEP_K2:  begin o_mul_x = MX_W'(k);       o_mul_y = MY_W'(k);      end
            STEP_KD:  begin o_mul_x = r_den;          o_mul_y = MY_W'(r_k2);   end
            default:  begin o_mul_x = '0;             o_mul_y = '0;            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= 15'(THR_RESET);
            r_keep   <= 1'b0;
            r_demean <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr    <= i_cfg_data[14:0];
                CFG_KEEP_SIGN: r_keep   <= i_cfg_data[0];
                CFG_DEMEAN:    r_demean <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.out_load) begin
            r_cnt <= '0;
            r_sa  <= '0;
            r_sb  <= '0;
            r_saa <= '0;
            r_sbb <= '0;
            r_sab <= '0;
        end else if (add_en) begin
            r_cnt <= r_cnt + CNT_W'(1);
            r_sa  <= r_sa + SUM_W'(a_s);
            r_sb  <= r_sb + SUM_W'(b_s);
            r_saa <= r_saa + SQ_W'(unsigned'(aa));
            r_sbb <= r_sbb + SQ_W'(unsigned'(bb));
            r_sab <= r_sab + SAB_W'(ab);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.raw_load) begin
            r_num <= V_W'(mag_sab);
            r_neg <= r_sab[SAB_W-1];
            r_va  <= V_W'(r_saa);
            r_vb  <= V_W'(r_sbb);
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= HI_INIT;
        end
        if (i_cmd.capture) begin
            case (i_cmd.step)
                STEP_P:  r_p <= pl;
                STEP_Q: begin
                    if (r_sab[SAB_W-1] == qneg) begin
                        r_num <= r_p + pl;
                        r_neg <= qneg;
                    end else if (r_p >= pl) begin
                        r_num <= r_p - pl;
                        r_neg <= r_sab[SAB_W-1];
                    end else begin
                        r_num <= pl - r_p;
                        r_neg <= qneg;
                    end
                end
                STEP_NA, STEP_NB: r_t <= pl;
                STEP_SA:  r_va  <= (r_t >= pl) ? r_t - pl : '0;
                STEP_SB:  r_vb  <= (r_t >= pl) ? r_t - pl : '0;
                STEP_DEN: r_den <= i_prod[MX_W-1:0];
                STEP_LHS: r_lhs <= {i_prod[MX_W-1:0], 32'd0};
                STEP_K2:  r_k2  <= i_prod[31:0];
                STEP_KD: begin
                    if (i_prod <= r_lhs) r_lo <= mid;
                    else                 r_hi <= mid - 16'd1;
                end
                default: ;
            endcase
        end
    end

    // r_lo tops out at 32768, which saturates
    assign sc_pos = (r_lo > 16'd32767) ? 16'd32767 : r_lo;
    assign score  = (r_keep && r_neg && (r_lo != '0)) ? signed'(16'(-r_lo))
                                                        : signed'(sc_pos);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (degen) begin
                r_out <= '{score: '0, above_threshold: 1'b0, degenerate: 1'b1};
            end else begin
                r_out <= '{score: score,
                           above_threshold: (score > signed'({1'b0, r_thr})),
                           degenerate: 1'b0};
            end
        end
    end

    assign o_out = r_out;

endmodule

>>> design/mpc_ctrl.sv
// ----------------------------------------------------------------------------
// mpc_ctrl: controller
// Sequences the finalize multiplies, the root search and the result request.
// ----------------------------------------------------------------------------
module mpc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  logic          i_mul_done,
    input  mpc_pkg::t_sts i_sts,
    output mpc_pkg::t_cmd o_cmd
);
    import mpc_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RAW    = 3'd1;
    localparam logic [2:0] ST_MSTART = 3'd2;
    localparam logic [2:0] ST_MWAIT  = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_SRCH   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_ovalid;
    logic              in_fire;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        o_cmd           = '0;
        o_cmd.step      = r_step;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_last) begin
                    if (i_sts.demean) begin
                        n_step  = STEP_P;
                        n_state = ST_MSTART;
                    end else begin
                        n_state = ST_RAW;
                    end
                end
            end
            ST_RAW: begin
                o_cmd.raw_load = 1'b1;
                n_state        = ST_CHECK;
            end
            ST_MSTART: begin
                o_cmd.mul_start = 1'b1;
                n_state         = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_mul_done) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_MSTART;
                    case (r_step)
                        STEP_P:   n_step = STEP_Q;
                        STEP_Q:   n_step = STEP_NA;
                        STEP_NA:  n_step = STEP_SA;
                        STEP_SA:  n_step = STEP_NB;
                        STEP_NB:  n_step = STEP_SB;
                        STEP_SB:  n_state = ST_CHECK;
                        STEP_DEN: n_step = STEP_LHS;
                        STEP_LHS: n_state = ST_SRCH;
                        STEP_K2:  n_step = STEP_KD;
                        STEP_KD:  n_state = ST_SRCH;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_CHECK: begin
                if (i_sts.degen) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_step          = STEP_DEN;
                    n_state         = ST_MSTART;
                end
            end
            ST_SRCH: begin
                if (i_sts.lo_lt_hi) begin
                    n_step  = STEP_K2;
                    n_state = ST_MSTART;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_ovalid) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_P;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (o_cmd.out_load)   r_ovalid <= 1'b1;
            else if (i_out_ready) r_ovalid <= 1'b0;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !r_ovalid)
        else $error("result overwritten before taken");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_last) |=> (r_state == ST_MSTART || r_state == ST_RAW))
        else $error("last voxel did not start finalize");

    a_srch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH && !i_sts.lo_lt_hi) |=> (r_state == ST_DONE))
        else $error("search did not end");

    a_capture_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> (r_state == ST_MWAIT && i_mul_done))
        else $error("capture without product");

endmodule

>>> design/masked_pearson_correlation.sv
// ----------------------------------------------------------------------------
// masked_pearson_correlation: masked correlation of two voxel streams
//
//   channel | direction | handshake                 | payload
//   in      | input     | i_in_valid / o_in_ready   | i_in  (t_in)
//   out     | output    | o_out_valid / i_out_ready | o_out (t_out)
//   cfg     | input     | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Voxels are taken one per cycle; each masked voxel, up to MAX_VOXELS,
// updates the sums on accept. A last voxel starts the finalize, driven by the
// bit-serial multiplier (one multiplier bit per cycle) and a 16-step search.
// No voxel is accepted during finalize. Reset is synchronous, active low.
// A result waits in its register until taken; the next volume streams in
// meanwhile, and its finalize holds only if that result is still waiting.
// ----------------------------------------------------------------------------
module masked_pearson_correlation #(
    parameter int MAX_VOXELS  = mpc_pkg::MAX_VOXELS_DEF,
    parameter int SAMPLE_BITS = mpc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mpc_pkg::t_in                  i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mpc_pkg::t_out                 o_out,
    input  logic                          i_cfg_we,
    input  logic [mpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mpc_pkg::CFG_DAT_W-1:0] i_cfg_data
);
    import mpc_pkg::*;

    t_cmd            cmd;
    t_sts            sts;
    logic [MX_W-1:0] mul_x;
    logic [MY_W-1:0] mul_y;
    logic [MP_W-1:0] prod;
    logic            mul_done;

    mpc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_in.last_voxel),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_mul_done  (mul_done),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mpc_dp #(
        .MAX_VOXELS  (MAX_VOXELS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (i_in_valid && o_in_ready),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_mul_x    (mul_x),
        .o_mul_y    (mul_y),
        .i_prod     (prod),
        .o_out      (o_out)
    );

    mpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cmd.mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_done  (mul_done),
        .o_prod  (prod)
    );

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for masked_pearson_correlation
// Streams voxel volumes through the block with random idling on both sides,
// predicts each volume's score, flags and degenerate bit with exact wide
// integer math, and compares them field by field with the block's results.
// ----------------------------------------------------------------------------
module tb_top;
    import mpc_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in                  in_req;
    logic                 out_valid;
    logic                 out_ready;
    t_out                 out_rsp;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_DAT_W-1:0] cfg_data;

    masked_pearson_correlation u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_rsp),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1; #4;
        clk = 1'b0; #4;
    end

    // predictor state
    logic [14:0]        thr_reg;
    logic               keep_sign_reg;
    logic               demean_reg;
    int unsigned        n_vox;
    logic signed [63:0] acc_a, acc_b, acc_aa, acc_bb, acc_ab;

    t_in  voxel_q[$];
    t_out score_q[$];
    int   n_errors;
    int   hold_reqs;
    bit   no_gaps;
    int   cycles;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    function automatic t_out correlate();
        logic signed [255:0] n, num, va, vb, mag, den, lhs, t;
        logic signed [255:0] k;
        int unsigned lo, hi, mid;
        t_out r;
        n = n_vox;
        if (demean_reg) begin
            num = n * acc_ab - acc_a * acc_b;
            va  = n * acc_aa - acc_a * acc_a;
            vb  = n * acc_bb - acc_b * acc_b;
            if (va < 0) va = 0;
            if (vb < 0) vb = 0;
        end else begin
            num = acc_ab;
            va  = acc_aa;
            vb  = acc_bb;
        end
        r = '0;
        if (va == 0 || vb == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        mag = (num < 0) ? -num : num;
        den = va * vb;
        lhs = (mag * mag) <<< 32;
        lo = 0;
        hi = 32768;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            k = 2 * mid - 1;
            t = k * k * den;
            if (t <= lhs) lo = mid;
            else hi = mid - 1;
        end
        if (keep_sign_reg && num < 0 && lo > 0) r.score = -$signed(lo);
        else r.score = (lo > 32767) ? 16'sd32767 : lo[15:0];
        r.above_threshold = ($signed(r.score) > $signed({1'b0, thr_reg}));
        return r;
    endfunction

    function automatic void accept_voxel(input t_in v);
        if (v.in_mask && n_vox < MAX_VOXELS_DEF) begin
            n_vox++;
            acc_a  += v.sample_a;
            acc_b  += v.sample_b;
            acc_aa += v.sample_a * v.sample_a;
            acc_bb += v.sample_b * v.sample_b;
            acc_ab += v.sample_a * v.sample_b;
        end
        if (v.last_voxel) begin
            score_q.push_back(correlate());
            n_vox = 0;
            acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0;
        end
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // request driver
    int gap_left;
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_req   <= '0;
            gap_left <= 0;
        end else if (in_valid && !in_ready) begin
            // hold the offered request
        end else if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (voxel_q.size() > 0) begin
            in_valid <= 1'b1;
            in_req   <= voxel_q.pop_front();
            gap_left <= gap_len();
        end else begin
            in_valid <= 1'b0;
        end
    end

    // result side: random stalls, plus long hold-offs on request
    int hold_left, hold_done;
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_done != hold_reqs) begin
            out_ready <= 1'b0;
            hold_left <= 3000;
            hold_done <= hold_reqs;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= no_gaps || ($urandom_range(99) < 70)
                         || ($urandom_range(99) < 50 && !out_ready);
        end
    end

    // monitor: predict on accepted requests, check accepted results
    t_out want;
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready)
            accept_voxel(in_req);
        if (rst_n && out_valid && out_ready) begin
            if (score_q.size() == 0) begin
                report_mismatch("unexpected result, score", out_rsp.score, 0);
            end else begin
                want = score_q.pop_front();
                if (out_rsp.score !== want.score)
                    report_mismatch("score", out_rsp.score, want.score);
                if (out_rsp.above_threshold !== want.above_threshold)
                    report_mismatch("above_threshold", out_rsp.above_threshold,
                                    want.above_threshold);
                if (out_rsp.degenerate !== want.degenerate)
                    report_mismatch("degenerate", out_rsp.degenerate, want.degenerate);
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_voxel(input int a, input int b, input bit m, input bit l);
        t_in v;
        v.sample_a   = a[15:0];
        v.sample_b   = b[15:0];
        v.in_mask    = m;
        v.last_voxel = l;
        voxel_q.push_back(v);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value[CFG_DAT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr_reg       = value[14:0];
            CFG_KEEP_SIGN: keep_sign_reg = value[0];
            CFG_DEMEAN:    demean_reg    = value[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (voxel_q.size() > 0 || in_valid || score_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic int rand_sample();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 32767;
        if (r == 1) return -32768;
        if (r < 5) return $signed($urandom_range(200)) - 100;
        return $signed($urandom_range(65535)) - 32768;
    endfunction

    function automatic int clip16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // random volumes: mostly short, with independent, correlated or anti-correlated pairs
    task automatic push_volumes(input int n_items);
        int left, len, rel, a, b, i;
        left = n_items;
        while (left > 0) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 17) : $urandom_range(16, 1);
            if (len > left) len = left;
            rel = $urandom_range(4);
            for (i = 0; i < len; i++) begin
                a = rand_sample();
                case (rel)
                    0: b = rand_sample();
                    1: b = clip16(a + $signed($urandom_range(2000)) - 1000);
                    2: b = clip16(-a + $signed($urandom_range(2000)) - 1000);
                    3: b = a;
                    default: b = clip16(-a);
                endcase
                push_voxel(a, b, $urandom_range(9) != 0, i == len - 1);
            end
            left -= len;
        end
    endtask

    task automatic push_directed();
        push_voxel(32767, 32767, 1, 0);
        push_voxel(-32768, -32768, 1, 0);
        push_voxel(0, 0, 1, 1);
        push_voxel(5, 5, 0, 1);                 // empty volume
        push_voxel(7, 1, 1, 0);                 // constant first sample
        push_voxel(7, -3, 1, 0);
        push_voxel(7, 9, 1, 1);
        push_voxel(100, -100, 1, 0);            // anti-correlated
        push_voxel(-100, 100, 1, 0);
        push_voxel(50, -50, 0, 0);
        push_voxel(30, -30, 1, 1);
        push_voxel(1, 2, 1, 0);                 // last voxel outside the mask
        push_voxel(3, 9, 1, 0);
        push_voxel(-5, 4, 1, 0);
        push_voxel(12345, -1, 0, 1);
        push_voxel(-32768, 32767, 1, 0);
        push_voxel(32767, -32768, 1, 0);
        push_voxel(-1, 1, 1, 1);
        push_voxel(0, 0, 1, 0);                 // all-zero raw sums
        push_voxel(0, 0, 1, 1);
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_data  = '0;
        n_errors  = 0;
        hold_reqs = 0;
        no_gaps   = 1'b0;
        cycles    = 0;
        thr_reg = THR_RESET[14:0]; keep_sign_reg = 1'b0; demean_reg = 1'b1;
        n_vox = 0;
        acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        push_directed();
        push_volumes(150);
        drain();

        write_reg(CFG_KEEP_SIGN, 1);
        write_reg(CFG_THRESHOLD, 0);
        push_directed();
        push_volumes(150);
        @(negedge clk) hold_reqs = hold_reqs + 1;
        drain();

        write_reg(CFG_THRESHOLD, 32767);
        write_reg(CFG_DEMEAN, 0);
        write_reg(CFG_KEEP_SIGN, 16'h7ffe);     // only bit 0 is kept
        write_reg(CFG_UNUSED, 12345);           // no such register
        no_gaps = 1'b1;
        push_directed();
        push_volumes(130);
        drain();

        no_gaps = 1'b0;
        write_reg(CFG_KEEP_SIGN, 1);
        write_reg(CFG_THRESHOLD, $urandom_range(32767));
        push_volumes(150);
        @(negedge clk) hold_reqs = hold_reqs + 1;
        drain();

        write_reg(CFG_DEMEAN, 16'h7fff);
        write_reg(CFG_THRESHOLD, 16384);
        push_volumes(180);
        drain();

        if (n_errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
design/mpc_pkg.sv
design/mpc_mul.sv
design/mpc_dp.sv
design/mpc_ctrl.sv
design/masked_pearson_correlation.sv
dv/tb_top.sv
